// ----- hdl/utf8_codepoint_decode_top_defines.svh -----
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Concurrent assertion helpers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef UTF8_CODEPOINT_DECODE_TOP_DEFINES_SVH
`define UTF8_CODEPOINT_DECODE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checks a property on every rising edge of clk while rst is low.
`define U8CD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("u8cd assertion failed");
// Checks that cond implies expr in the same cycle.
`define U8CD_IMPLIES(label, clk, rst, cond, expr) \
  `U8CD_ASSERT(label, clk, rst, (cond) |-> (expr))
`else
`define U8CD_ASSERT(label, clk, rst, prop)
`define U8CD_IMPLIES(label, clk, rst, cond, expr)
`endif

`endif

// ----- hdl/u8cd_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Word types and byte-class constants shared by the decoder and its users.
// ----------------------------------------------------------------------------
package u8cd_pkg;

  localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;
  localparam logic [2:0]  MAX_LEFT         = 3'd4;

  localparam logic [7:0] MASK_2B = 8'hE0;
  localparam logic [7:0] LEAD_2B = 8'hC0;
  localparam logic [7:0] MASK_3B = 8'hF0;
  localparam logic [7:0] LEAD_3B = 8'hE0;
  localparam logic [7:0] MASK_4B = 8'hF8;
  localparam logic [7:0] LEAD_4B = 8'hF0;
  localparam logic [7:0] MASK_CONT = 8'hC0;
  localparam logic [7:0] TAG_CONT  = 8'h80;

  typedef struct packed {
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [2:0] bytes_left;
  } item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  advance;
    logic        error_flag;
  } result_t;

endpackage

// ----- hdl/utf8_codepoint_decode_top.sv -----
// ----------------------------------------------------------------------------
// UTF-8 code point decoder
// Decodes one code point from a four-byte window per cycle, three stages deep.
// ----------------------------------------------------------------------------
//  Channel   Signals              Handshake
//  -------   -------------------  ------------------------------------------
//  input     start, busy, item    word taken when start is high, busy is low
//  result    done, result         word valid for the one cycle done is high
//
// A word taken at the input passes through the three register stages, s1,
// s2 and result, before its result shows with done high.
// One word may enter every cycle; busy is held low since nothing stalls.
// Synchronous active-high reset clears the stage valid bits only.
// The receiver cannot stall, so the pipeline never holds back.
// ----------------------------------------------------------------------------
`include "utf8_codepoint_decode_top_defines.svh"

module utf8_codepoint_decode_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  u8cd_pkg::item_t   item,
  output logic              done,
  output u8cd_pkg::result_t result
);

  // Stage 1: lead byte classified, continuation tags checked.
  typedef struct packed {
    logic [7:0] lead;
    logic [5:0] p1;
    logic [5:0] p2;
    logic [5:0] p3;
    logic [1:0] tail;
    logic       lead_bad;
    logic [2:0] left;
    logic [2:0] cont_ok;
  } s1_t;

  // Stage 2: code point assembled, error cases resolved to flags.
  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  adv;
    logic [2:0]  left;
    logic        empty;
    logic        lead_bad;
    logic        trunc;
    logic        cont_bad;
  } s2_t;

  logic   v1, v2;
  s1_t    s1, s1_next;
  s2_t    s2, s2_next;
  u8cd_pkg::result_t res_next;

  assign busy = 1'b0;

  always_comb begin
    s1_next.lead = item.byte_0;
    s1_next.p1   = item.byte_1[5:0];
    s1_next.p2   = item.byte_2[5:0];
    s1_next.p3   = item.byte_3[5:0];
    s1_next.left = (item.bytes_left > u8cd_pkg::MAX_LEFT) ? u8cd_pkg::MAX_LEFT
                                                          : item.bytes_left;
    s1_next.cont_ok[0] = (item.byte_1 & u8cd_pkg::MASK_CONT) == u8cd_pkg::TAG_CONT;
    s1_next.cont_ok[1] = (item.byte_2 & u8cd_pkg::MASK_CONT) == u8cd_pkg::TAG_CONT;
    s1_next.cont_ok[2] = (item.byte_3 & u8cd_pkg::MASK_CONT) == u8cd_pkg::TAG_CONT;
    s1_next.lead_bad = 1'b0;
    if (!item.byte_0[7]) begin
      s1_next.tail = 2'd0;
    end else if ((item.byte_0 & u8cd_pkg::MASK_2B) == u8cd_pkg::LEAD_2B) begin
      s1_next.tail = 2'd1;
    end else if ((item.byte_0 & u8cd_pkg::MASK_3B) == u8cd_pkg::LEAD_3B) begin
      s1_next.tail = 2'd2;
    end else if ((item.byte_0 & u8cd_pkg::MASK_4B) == u8cd_pkg::LEAD_4B) begin
      s1_next.tail = 2'd3;
    end else begin
      s1_next.tail     = 2'd0;
      s1_next.lead_bad = 1'b1;
    end
  end

  always_comb begin
    case (s1.tail)
      2'd0:    s2_next.cp = {14'd0, s1.lead[6:0]};
      2'd1:    s2_next.cp = {10'd0, s1.lead[4:0], s1.p1};
      2'd2:    s2_next.cp = {5'd0, s1.lead[3:0], s1.p1, s1.p2};
      default: s2_next.cp = {s1.lead[2:0], s1.p1, s1.p2, s1.p3};
    endcase
    s2_next.adv      = {1'b0, s1.tail} + 3'd1;
    s2_next.left     = s1.left;
    s2_next.empty    = s1.left == 3'd0;
    s2_next.lead_bad = s1.lead_bad;
    s2_next.trunc    = s2_next.adv > s1.left;
    // Only the bytes that belong to the sequence must carry the continuation tag.
    s2_next.cont_bad = (s1.tail >= 2'd1 && !s1.cont_ok[0]) ||
                       (s1.tail >= 2'd2 && !s1.cont_ok[1]) ||
                       (s1.tail == 2'd3 && !s1.cont_ok[2]);
  end

  always_comb begin
    if (s2.empty) begin
      res_next.code_point = 21'd0;
      res_next.advance    = 3'd0;
      res_next.error_flag = 1'b0;
    end else if (s2.lead_bad) begin
      res_next.code_point = u8cd_pkg::REPLACEMENT_CHAR;
      res_next.advance    = 3'd1;
      res_next.error_flag = 1'b1;
    end else if (s2.trunc) begin
      res_next.code_point = u8cd_pkg::REPLACEMENT_CHAR;
      res_next.advance    = s2.left;
      res_next.error_flag = 1'b1;
    end else if (s2.cont_bad) begin
      res_next.code_point = u8cd_pkg::REPLACEMENT_CHAR;
      res_next.advance    = 3'd1;
      res_next.error_flag = 1'b1;
    end else begin
      res_next.code_point = s2.cp;
      res_next.advance    = s2.adv;
      res_next.error_flag = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      done <= v2;
    end
    s1     <= s1_next;
    s2     <= s2_next;
    result <= res_next;
  end

  `U8CD_ASSERT(a_latency, clk, rst, (start && !busy) |-> ##3 done)
  `U8CD_IMPLIES(a_err_repl, clk, rst, done && result.error_flag,
                result.code_point == u8cd_pkg::REPLACEMENT_CHAR)
  `U8CD_IMPLIES(a_zero_adv, clk, rst, done && result.advance == 3'd0,
                !result.error_flag && result.code_point == 21'd0)
  `U8CD_IMPLIES(a_ascii, clk, rst,
                done && !result.error_flag && result.advance == 3'd1,
                result.code_point < 21'd128)

endmodule
